[design/snng_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snng_pkg: shared types and constants of the sector grouping unit
// Field widths, register indexes and reset values, and the control word that
// travels from the front end to the emission engine.
// ----------------------------------------------------------------------------
package snng_pkg;

	localparam int IDX_W     = 6;   // customer_index, group_index, slot_in_group
	localparam int SECTOR_W  = 4;
	localparam int GS_W      = 7;
	localparam int SEC_REG_W = 5;
	localparam int PL_W      = 7;
	localparam int CFG_W     = 7;   // widest register
	localparam int CFG_IDX_W = 2;
	localparam int IN_DIST_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_IN_USE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_LIMIT  = 2'd2;

	localparam logic [GS_W-1:0]      GROUP_SIZE_RST     = 7'd8;
	localparam logic [SEC_REG_W-1:0] SECTORS_RST        = 5'd8;
	localparam logic [PL_W-1:0]      PRIMARY_LIMIT_RST  = 7'd2;

	typedef struct packed {
		logic [GS_W-1:0]      group_size;
		logic [SEC_REG_W-1:0] sectors_in_use;
		logic [PL_W-1:0]      primary_limit;
	} cfg_t;

	// Control part of one queued word; the distance travels beside it.
	typedef struct packed {
		logic             store;     // word lands in the customer store
		logic             exclude;
		logic             last;
		logic [IDX_W-1:0] idx;       // store entry assigned by the front end
		logic [SECTOR_W-1:0] sector;
	} item_ctl_t;

endpackage
`default_nettype wire

[design/snng_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snng_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module snng_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[design/snng_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snng_front: input front end
// Accepts customer words, trims the distance, assigns store entries and
// marks words beyond the store's depth as dropped.
// ----------------------------------------------------------------------------
module snng_front #(
	parameter int CUSTOMERS  = 64,
	parameter int DIST_WIDTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  item_valid,
	output logic                                       item_ready,
	input  wire logic [snng_pkg::IN_DIST_W-1:0]        distance,
	input  wire logic [snng_pkg::SECTOR_W-1:0]         sector,
	input  wire logic                                  exclude,
	input  wire logic                                  last_customer,
	output logic                                       push_valid,
	input  wire logic                                  push_ready,
	output snng_pkg::item_ctl_t                        push_ctl,
	output logic      [DIST_WIDTH-1:0]                 push_dist
);
	import snng_pkg::*;

	localparam int LCW = $clog2(CUSTOMERS + 1);

	logic [LCW-1:0] cnt_q;
	logic [63:0]    dist_ext;
	logic           accept;

	assign item_ready = push_ready;
	assign push_valid = item_valid;
	assign accept     = item_valid & push_ready;
	assign dist_ext   = {32'b0, distance};
	assign push_dist  = dist_ext[DIST_WIDTH-1:0];

	always_comb begin
		push_ctl.store   = (cnt_q < LCW'(CUSTOMERS));
		push_ctl.exclude = exclude;
		push_ctl.last    = last_customer;
		push_ctl.idx     = IDX_W'(cnt_q);
		push_ctl.sector  = sector;
	end

	// Entry counter restarts after each last word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (last_customer) begin
				cnt_q <= '0;
			end else if (cnt_q < LCW'(CUSTOMERS)) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[design/snng_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snng_queue: two-entry word queue
// Decouples the front end from the emission engine.
// ----------------------------------------------------------------------------
module snng_queue #(
	parameter int WIDTH = 43
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = slot_q[rptr_q];
	assign push     = wr_valid & wr_ready;
	assign pop      = rd_valid & rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

[design/snng_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snng_back: customer store and emission engine
// Stores queued words; on the last word, picks sector leaders and then the
// nearest unused customers, one full store scan per pick.
// ----------------------------------------------------------------------------
module snng_back #(
	parameter int CUSTOMERS  = 64,
	parameter int DIST_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire snng_pkg::cfg_t                    cfg,
	input  wire logic                              q_valid,
	output logic                                   q_ready,
	input  wire snng_pkg::item_ctl_t               q_ctl,
	input  wire logic [DIST_WIDTH-1:0]             q_dist,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output logic      [snng_pkg::IDX_W-1:0]        customer_index,
	output logic      [snng_pkg::IDX_W-1:0]        group_index,
	output logic      [snng_pkg::IDX_W-1:0]        slot_in_group,
	output logic                                   primary,
	output logic                                   last_result
);
	import snng_pkg::*;

	localparam int AW  = $clog2(CUSTOMERS);
	localparam int LCW = $clog2(CUSTOMERS + 1);
	localparam int RW  = DIST_WIDTH + SECTOR_W;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_START = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_PICK  = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [LCW-1:0]         load_cnt_q;
	logic [LCW-1:0]         nbr_q;
	logic [CUSTOMERS-1:0]   used_q;
	logic [LCW-1:0]         placed_q;
	logic [GS_W-1:0]        slot_q;
	logic [IDX_W-1:0]       grp_q;
	logic                   sec_mode_q;
	logic [SEC_REG_W-1:0]   sec_q;
	logic [LCW-1:0]         idx_q;
	logic                   rd_v_s1;
	logic [AW-1:0]          rd_idx_s1;
	logic                   found_q;
	logic [DIST_WIDTH-1:0]  best_d_q;
	logic [AW-1:0]          best_idx_q;
	logic                   result_valid_q;

	logic                   q_pop;
	logic                   ram_we;
	logic [RW-1:0]          ram_rdata;
	logic [DIST_WIDTH-1:0]  rd_dist;
	logic [SECTOR_W-1:0]    rd_sec;
	logic                   issue;
	logic                   hit;
	logic                   scan_done;
	logic                   out_free;
	logic [GS_W-1:0]        gs;
	logic                   do_pick;
	logic                   step;
	logic [LCW-1:0]         placed_nx;
	logic                   all_done;
	logic [7:0]             first_size;
	logic                   sec_ok;

	snng_ram #(
		.WIDTH (RW),
		.DEPTH (CUSTOMERS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (q_ctl.idx[AW-1:0]),
		.wdata ({q_ctl.sector, q_dist}),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign q_ready   = (state_q == ST_LOAD);
	assign q_pop     = q_valid & q_ready;
	assign ram_we    = q_pop & q_ctl.store;
	assign rd_dist   = ram_rdata[DIST_WIDTH-1:0];
	assign rd_sec    = ram_rdata[RW-1:DIST_WIDTH];
	assign issue     = (state_q == ST_SCAN) && (idx_q < load_cnt_q);
	assign scan_done = (state_q == ST_SCAN) && !issue && !rd_v_s1;
	assign out_free  = !result_valid_q || result_ready;
	assign gs        = (cfg.group_size == '0) ? GS_W'(1) : cfg.group_size;
	assign do_pick   = (state_q == ST_PICK) && found_q && out_free;
	assign step      = (state_q == ST_PICK) && (!found_q || out_free);
	assign placed_nx = placed_q + LCW'(found_q);
	assign all_done  = (placed_nx == nbr_q);

	// Candidate test on the word read last cycle; strict less keeps the lowest index.
	assign hit = rd_v_s1 && !used_q[rd_idx_s1]
		&& (!sec_mode_q || ({1'b0, rd_sec} == sec_q))
		&& (!found_q || (rd_dist < best_d_q));

	always_comb begin
		first_size = (8'(nbr_q) < 8'(gs)) ? 8'(nbr_q) : 8'(gs);
		sec_ok     = (cfg.sectors_in_use != '0) && (8'(cfg.sectors_in_use) <= first_size);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			load_cnt_q     <= '0;
			nbr_q          <= '0;
			used_q         <= '0;
			placed_q       <= '0;
			slot_q         <= '0;
			grp_q          <= '0;
			sec_mode_q     <= 1'b0;
			sec_q          <= '0;
			idx_q          <= '0;
			rd_v_s1        <= 1'b0;
			found_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (do_pick) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (q_pop) begin
						if (q_ctl.store) begin
							load_cnt_q             <= load_cnt_q + 1'b1;
							used_q[q_ctl.idx[AW-1:0]] <= q_ctl.exclude;
							if (!q_ctl.exclude) begin
								nbr_q <= nbr_q + 1'b1;
							end
						end
						if (q_ctl.last) begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					placed_q <= '0;
					slot_q   <= '0;
					grp_q    <= '0;
					sec_q    <= '0;
					idx_q    <= '0;
					found_q  <= 1'b0;
					if (nbr_q == '0) begin
						used_q     <= '0;
						load_cnt_q <= '0;
						state_q    <= ST_LOAD;
					end else begin
						sec_mode_q <= sec_ok;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (hit) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (step) begin
						if (found_q) begin
							if (!all_done) begin
								used_q[best_idx_q] <= 1'b1;
							end
							placed_q           <= placed_nx;
							if (slot_q == gs - 1'b1) begin
								slot_q <= '0;
								grp_q  <= grp_q + 1'b1;
							end else begin
								slot_q <= slot_q + 1'b1;
							end
						end
						if (sec_mode_q) begin
							sec_q <= sec_q + 1'b1;
							if (sec_q + 1'b1 == cfg.sectors_in_use) begin
								sec_mode_q <= 1'b0;
							end
						end
						idx_q   <= '0;
						found_q <= 1'b0;
						if (all_done) begin
							used_q     <= '0;
							load_cnt_q <= '0;
							nbr_q      <= '0;
							state_q    <= ST_LOAD;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Scan payload and result word.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[AW-1:0];
		if (hit) begin
			best_d_q   <= rd_dist;
			best_idx_q <= rd_idx_s1;
		end
		if (do_pick) begin
			customer_index <= IDX_W'(best_idx_q);
			group_index    <= grp_q;
			slot_in_group  <= slot_q[IDX_W-1:0];
			primary        <= ({1'b0, grp_q} < cfg.primary_limit);
			last_result    <= all_done;
		end
	end

	assign result_valid = result_valid_q;

	a_placed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) || (state_q == ST_PICK)) |-> (placed_q <= nbr_q))
		else $error("placed count ran past neighbor count");

	a_nbr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nbr_q <= load_cnt_q)
		else $error("neighbor count exceeds load count");

	a_pick_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PICK) && found_q |-> !used_q[best_idx_q])
		else $error("picked a customer already used");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (slot_q < gs))
		else $error("slot index out of group range");

endmodule
`default_nettype wire

[design/sector_nearest_neighbor_grouping_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sector_nearest_neighbor_grouping_unit: sector-seeded nearest-customer grouping
// Loads customers one word at a time and, on the last one, emits every
// stored, non-excluded customer in groups, sector leaders first when they fit.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  -------   --------------------------   -----------------------------------------
//  item      item_valid / item_ready      distance, sector, exclude, last_customer
//  result    result_valid / result_ready  customer_index, group_index,
//                                         slot_in_group, primary, last_result
//  config    cfg_wen (no wait)            cfg_idx, cfg_wdata
//
//  A loaded word passes the front end combinationally and is registered in
//  the two-entry queue. Each emitted word costs one scan of the store, set
//  by the single read port of the customer store; a sector with no customer
//  costs a scan without a result. Reset clears counters, used flags and
//  valid state; the store needs none. A stalled result port holds the engine
//  at its next pick; meanwhile the queue takes up to two words of the next
//  load and then holds item_ready low.
// ----------------------------------------------------------------------------
module sector_nearest_neighbor_grouping_unit #(
	parameter int CUSTOMERS  = 64,
	parameter int DIST_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              item_valid,
	output logic                                   item_ready,
	input  wire logic [snng_pkg::IN_DIST_W-1:0]    distance,
	input  wire logic [snng_pkg::SECTOR_W-1:0]     sector,
	input  wire logic                              exclude,
	input  wire logic                              last_customer,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output logic      [snng_pkg::IDX_W-1:0]        customer_index,
	output logic      [snng_pkg::IDX_W-1:0]        group_index,
	output logic      [snng_pkg::IDX_W-1:0]        slot_in_group,
	output logic                                   primary,
	output logic                                   last_result,
	input  wire logic                              cfg_wen,
	input  wire logic [snng_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [snng_pkg::CFG_W-1:0]        cfg_wdata
);
	import snng_pkg::*;

	localparam int QW = $bits(item_ctl_t) + DIST_WIDTH;

	cfg_t                  cfg_q;
	logic                  push_valid;
	logic                  push_ready;
	item_ctl_t             push_ctl;
	logic [DIST_WIDTH-1:0] push_dist;
	logic                  pop_valid;
	logic                  pop_ready;
	logic [QW-1:0]         pop_data;
	item_ctl_t             pop_ctl;
	logic [DIST_WIDTH-1:0] pop_dist;

	// Register file: index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.group_size     <= GROUP_SIZE_RST;
			cfg_q.sectors_in_use <= SECTORS_RST;
			cfg_q.primary_limit  <= PRIMARY_LIMIT_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				CFG_GROUP_SIZE:     cfg_q.group_size     <= cfg_wdata[GS_W-1:0];
				CFG_SECTORS_IN_USE: cfg_q.sectors_in_use <= cfg_wdata[SEC_REG_W-1:0];
				CFG_PRIMARY_LIMIT:  cfg_q.primary_limit  <= cfg_wdata[PL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: take words, assign store entries, mark overflow drops.
	snng_front #(
		.CUSTOMERS  (CUSTOMERS),
		.DIST_WIDTH (DIST_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.distance      (distance),
		.sector        (sector),
		.exclude       (exclude),
		.last_customer (last_customer),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_ctl      (push_ctl),
		.push_dist     (push_dist)
	);

	// Queue between the two halves so either side can stall alone.
	snng_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  ({push_ctl, push_dist}),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (pop_data)
	);

	assign pop_ctl  = pop_data[QW-1:DIST_WIDTH];
	assign pop_dist = pop_data[DIST_WIDTH-1:0];

	// Back end: store, scan, pick, emit.
	snng_back #(
		.CUSTOMERS  (CUSTOMERS),
		.DIST_WIDTH (DIST_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_valid        (pop_valid),
		.q_ready        (pop_ready),
		.q_ctl          (pop_ctl),
		.q_dist         (pop_dist),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.customer_index (customer_index),
		.group_index    (group_index),
		.slot_in_group  (slot_in_group),
		.primary        (primary),
		.last_result    (last_result)
	);

endmodule
`default_nettype wire
